// ----- src/p2ac_pkg.sv -----
// p2ac_pkg: shared types and constants of the postfix code generator
`default_nettype none
package p2ac_pkg;

  // instruction codes
  typedef enum logic [2:0] {
    OP_LD = 3'd0,
    OP_AD = 3'd1,
    OP_SB = 3'd2,
    OP_ML = 3'd3,
    OP_DV = 3'd4,
    OP_ST = 3'd5
  } opcode_t;

  // status codes
  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_UNDERFLOW  = 3'd1,
    ST_BADCHAR    = 3'd2,
    ST_UNBALANCED = 3'd3,
    ST_OVERFLOW   = 3'd4,
    ST_TEMPOVF    = 3'd5
  } status_t;

  // character codes
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // stack entry: temp flag over an 8-bit value
  typedef struct packed {
    logic       is_temp;
    logic [7:0] value;
  } entry_t;

  // one result word
  typedef struct packed {
    opcode_t    opcode;
    entry_t     operand;
    status_t    status;
    logic       last_of_run;
  } result_t;

  // map an operator character to its instruction, OP_LD when none
  function automatic opcode_t arith_code(input logic [7:0] c);
    opcode_t r;
    case (c)
      CH_PLUS:  r = OP_AD;
      CH_MINUS: r = OP_SB;
      CH_STAR:  r = OP_ML;
      CH_SLASH: r = OP_DV;
      default:  r = OP_LD;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/p2ac_if.sv -----
// p2ac_if: input and result channel interfaces
`default_nettype none
interface p2ac_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

interface p2ac_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic       operand_is_temp;
  logic [7:0] operand_value;
  logic [2:0] status;
  logic       last_of_run;
  modport source (output valid, output opcode, output operand_is_temp,
                  output operand_value, output status, output last_of_run,
                  input ready);
  modport sink   (input valid, input opcode, input operand_is_temp,
                  input operand_value, input status, input last_of_run,
                  output ready);
endinterface
`default_nettype wire

// ----- src/postfix_to_accumulator_code.sv -----
// postfix_to_accumulator_code: postfix characters to accumulator instructions
//
//   channel  dir  payload                                          handshake
//   in_chan  in   ch[7:0], last                                    valid/ready
//   out_chan out  opcode[2:0], operand_is_temp, operand_value[7:0],
//                 status[2:0], last_of_run                         valid/ready
//
// A letter pushes the stack; an operator queues three instruction words (two at
// the expression's end) for the single result port, which drains a four-word queue.
// The top two stack entries sit in registers, the rest in a ram; an operator
// refills the second entry from the registered ram read, holding off input.
// Reset clears the stack pointer, temp counter, error flag and queue; the ram
// is not cleared. A stalled result port holds the queue; a new character is
// taken while up to one word still waits.
`default_nettype none
module postfix_to_accumulator_code
  import p2ac_pkg::*;
#(
  parameter int STACK_DEPTH = 64,
  parameter int MAX_TEMPS   = 255
) (
  input wire logic   clk,
  input wire logic   rst_n,
  p2ac_in_if.sink    in_chan,
  p2ac_out_if.source out_chan
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int TW = $clog2(MAX_TEMPS + 1);

  logic [CW-1:0] sp_r, sp_nxt;
  entry_t        tos_r, tos_nxt;
  entry_t        nos_r, nos_nxt;
  logic [TW-1:0] temp_r, temp_nxt;
  logic          err_r, err_nxt;
  logic          fill_r, fill_nxt;
  logic [2:0]    qcnt_r, qcnt_nxt;
  result_t       res_r [4];
  result_t       res_nxt [4];

  logic          accept, pop;
  logic          is_letter;
  opcode_t       code;
  logic          clear, fail;
  status_t       fail_st;
  logic [1:0]    new_n;
  result_t       new_res [4];
  logic [TW-1:0] temp_inc;
  logic [TW+7:0] temp_ext;
  entry_t        tmp_entry;
  logic [CW-1:0] sp_m2, sp_m3;
  logic          ram_we, ram_re;
  logic [8:0]    ram_rdata;
  logic [2:0]    qpop;
  logic [2:0]    j;
  result_t       sh [4];

  // handshakes
  assign in_chan.ready = (qcnt_r <= 3'd1) && !fill_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign pop           = out_chan.valid && out_chan.ready;

  // character decode
  assign code      = arith_code(in_chan.ch);
  assign is_letter = ((in_chan.ch >= CH_UP_A) && (in_chan.ch <= CH_UP_Z)) ||
                     ((in_chan.ch >= CH_LO_A) && (in_chan.ch <= CH_LO_Z));

  // fresh temporary
  assign temp_inc  = temp_r + 1'b1;
  assign temp_ext  = {8'd0, temp_inc};
  assign tmp_entry = '{is_temp: 1'b1, value: temp_ext[7:0]};
  assign sp_m2     = sp_r - CW'(2);
  assign sp_m3     = sp_r - CW'(3);

  // operand stack below the top two entries
  p2ac_ram #(
    .WIDTH(9),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sp_m2[AW-1:0]),
    .wdata (nos_r),
    .re    (ram_re),
    .raddr (sp_m3[AW-1:0]),
    .rdata (ram_rdata)
  );

  // per-word decode and stack update
  always_comb begin
    sp_nxt   = sp_r;
    tos_nxt  = tos_r;
    nos_nxt  = fill_r ? entry_t'(ram_rdata) : nos_r;
    temp_nxt = temp_r;
    err_nxt  = err_r;
    fill_nxt = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    clear    = 1'b0;
    fail     = 1'b0;
    fail_st  = ST_OK;
    new_n    = 2'd0;
    for (int i = 0; i < 4; i++) begin
      new_res[i] = '{opcode: OP_LD, operand: '0, status: ST_OK, last_of_run: 1'b0};
    end
    if (accept) begin
      if (err_r) begin
        clear = in_chan.last;
      end else if (is_letter) begin
        if (sp_r == CW'(STACK_DEPTH)) begin
          fail    = 1'b1;
          fail_st = ST_OVERFLOW;
        end else if (in_chan.last) begin
          if (sp_r != '0) begin
            fail    = 1'b1;
            fail_st = ST_UNBALANCED;
          end else begin
            clear = 1'b1;
          end
        end else begin
          ram_we  = (sp_r >= CW'(2));
          nos_nxt = tos_r;
          tos_nxt = '{is_temp: 1'b0, value: in_chan.ch};
          sp_nxt  = sp_r + 1'b1;
        end
      end else if (code != OP_LD) begin
        if (sp_r < CW'(2)) begin
          fail    = 1'b1;
          fail_st = ST_UNDERFLOW;
        end else if (temp_r >= TW'(MAX_TEMPS)) begin
          fail    = 1'b1;
          fail_st = ST_TEMPOVF;
        end else if (in_chan.last) begin
          if (sp_r != CW'(2)) begin
            fail    = 1'b1;
            fail_st = ST_UNBALANCED;
          end else begin
            new_n      = 2'd2;
            new_res[0] = '{opcode: OP_LD, operand: nos_r, status: ST_OK,
                           last_of_run: 1'b0};
            new_res[1] = '{opcode: code, operand: tos_r, status: ST_OK,
                           last_of_run: 1'b1};
            clear      = 1'b1;
          end
        end else begin
          new_n      = 2'd3;
          new_res[0] = '{opcode: OP_LD, operand: nos_r, status: ST_OK,
                         last_of_run: 1'b0};
          new_res[1] = '{opcode: code, operand: tos_r, status: ST_OK,
                         last_of_run: 1'b0};
          new_res[2] = '{opcode: OP_ST, operand: tmp_entry, status: ST_OK,
                         last_of_run: 1'b1};
          tos_nxt    = tmp_entry;
          temp_nxt   = temp_inc;
          sp_nxt     = sp_r - 1'b1;
          ram_re     = (sp_r >= CW'(3));
          fill_nxt   = (sp_r >= CW'(3));
        end
      end else begin
        fail    = 1'b1;
        fail_st = ST_BADCHAR;
      end
      // error word
      if (fail) begin
        new_n      = 2'd1;
        new_res[0] = '{opcode: OP_LD, operand: '0, status: fail_st,
                       last_of_run: 1'b1};
        if (in_chan.last) begin
          clear = 1'b1;
        end else begin
          err_nxt = 1'b1;
        end
      end
      // end of expression
      if (clear) begin
        sp_nxt   = '0;
        temp_nxt = '0;
        err_nxt  = 1'b0;
        fill_nxt = 1'b0;
        ram_re   = 1'b0;
      end
    end
  end

  // result queue: shift out at the head, append behind the remaining words
  always_comb begin
    qpop = qcnt_r - {2'd0, pop};
    for (int i = 0; i < 4; i++) begin
      if (pop) begin
        sh[i] = (i < 3) ? res_r[(i < 3) ? i + 1 : 3] : res_r[3];
      end else begin
        sh[i] = res_r[i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      j = 3'(i) - qpop;
      if (3'(i) < qpop) begin
        res_nxt[i] = sh[i];
      end else if (j < {1'b0, new_n}) begin
        res_nxt[i] = new_res[j[1:0]];
      end else begin
        res_nxt[i] = sh[i];
      end
    end
    qcnt_nxt = qpop + {1'b0, new_n};
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r   <= '0;
      temp_r <= '0;
      err_r  <= 1'b0;
      fill_r <= 1'b0;
      qcnt_r <= '0;
    end else begin
      sp_r   <= sp_nxt;
      temp_r <= temp_nxt;
      err_r  <= err_nxt;
      fill_r <= fill_nxt;
      qcnt_r <= qcnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tos_r <= tos_nxt;
    nos_r <= nos_nxt;
    for (int i = 0; i < 4; i++) begin
      res_r[i] <= res_nxt[i];
    end
  end

  // result port
  assign out_chan.valid           = (qcnt_r != 3'd0);
  assign out_chan.opcode          = res_r[0].opcode;
  assign out_chan.operand_is_temp = res_r[0].operand.is_temp;
  assign out_chan.operand_value   = res_r[0].operand.value;
  assign out_chan.status          = res_r[0].status;
  assign out_chan.last_of_run     = res_r[0].last_of_run;

  // checks
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= 3'd4)
    else $error("result queue over capacity");

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_chan.last) |=> (sp_r == '0) && (temp_r == '0) && !err_r)
    else $error("expression state not cleared after last character");

  a_error_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status != ST_OK)) |-> out_chan.last_of_run)
    else $error("error word not marked as last of run");

  a_refill_single: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r |=> !fill_r)
    else $error("second entry refill lasted more than one cycle");

endmodule
`default_nettype wire

// ----- src/p2ac_ram.sv -----
// p2ac_ram: generic single-write, single-read ram with registered read
`default_nettype none
module p2ac_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_postfix_to_accumulator_code.sv -----
`timescale 1ns / 1ps
// tb_postfix_to_accumulator_code: self-checking bench for the postfix to accumulator code block
module tb_postfix_to_accumulator_code;
  import p2ac_pkg::*;

  localparam int STACK_DEPTH  = 64;
  localparam int MAX_TEMPS    = 255;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_AT      = 30;
  localparam int HOLD_CYCLES  = 300;
  localparam int CALM_FROM    = 45;
  localparam int CALM_TO      = 100;
  localparam int PRINT_MAX    = 50;

  // one input word and one predicted instruction word
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  typedef struct {
    opcode_t    op;
    logic       is_temp;
    logic [7:0] value;
    status_t    st;
    logic       run_end;
  } instr_word_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  p2ac_in_if  in_chan ();
  p2ac_out_if out_chan ();

  postfix_to_accumulator_code #(
    .STACK_DEPTH(STACK_DEPTH),
    .MAX_TEMPS  (MAX_TEMPS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  char_word_t  pending_q[$];
  instr_word_t instr_q[$];
  int          n_errors  = 0;
  int          n_taken   = 0;
  int          cycle_cnt = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  // shadow copy of the expression state
  entry_t      shadow_stack [STACK_DEPTH];
  int          shadow_depth;
  int          shadow_temps;
  bit          shadow_err;

  // known levels before the first edge
  initial begin
    in_chan.valid  = 1'b0;
    in_chan.ch     = '0;
    in_chan.last   = 1'b0;
    out_chan.ready = 1'b0;
  end

  // random idling, switched off inside the calm window
  function bit take_break();
    if (n_taken >= CALM_FROM && n_taken < CALM_TO) return 1'b0;
    return $urandom_range(0, 99) < 32;
  endfunction

  task automatic report(input string msg);
    n_errors++;
    if (n_errors <= PRINT_MAX) $display("tb: mismatch at cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic clear_expr();
    shadow_depth = 0;
    shadow_temps = 0;
    shadow_err   = 1'b0;
  endtask

  task automatic push_instr(input opcode_t op, input entry_t e, input status_t st,
                            input logic run_end);
    instr_word_t w;
    w.op      = op;
    w.is_temp = e.is_temp;
    w.value   = e.value;
    w.st      = st;
    w.run_end = run_end;
    instr_q = {instr_q, w};
  endtask

  // an error gives one status word, then drops the rest of the expression
  task automatic flag_error(input status_t st, input logic lst);
    push_instr(OP_LD, '0, st, 1'b1);
    if (lst) clear_expr();
    else shadow_err = 1'b1;
  endtask

  // expected instruction words for one accepted character
  task automatic predict_instrs(input logic [7:0] c, input logic lst);
    opcode_t op;
    entry_t  lhs;
    entry_t  rhs;
    entry_t  tmp;
    bit      letter;
    case (c)
      CH_PLUS:  op = OP_AD;
      CH_MINUS: op = OP_SB;
      CH_STAR:  op = OP_ML;
      CH_SLASH: op = OP_DV;
      default:  op = OP_LD;
    endcase
    letter = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
    if (shadow_err) begin
      if (lst) clear_expr();
    end else if (letter) begin
      if (shadow_depth >= STACK_DEPTH) begin
        flag_error(ST_OVERFLOW, lst);
      end else begin
        shadow_stack[shadow_depth] = '{is_temp: 1'b0, value: c};
        shadow_depth++;
        if (lst) begin
          if (shadow_depth != 1) flag_error(ST_UNBALANCED, 1'b1);
          else clear_expr();
        end
      end
    end else if (op != OP_LD) begin
      if (shadow_depth < 2) begin
        flag_error(ST_UNDERFLOW, lst);
      end else if (shadow_temps >= MAX_TEMPS) begin
        flag_error(ST_TEMPOVF, lst);
      end else begin
        rhs = shadow_stack[shadow_depth - 1];
        lhs = shadow_stack[shadow_depth - 2];
        shadow_depth--;
        shadow_temps++;
        tmp = '{is_temp: 1'b1, value: 8'(shadow_temps)};
        shadow_stack[shadow_depth - 1] = tmp;
        if (lst) begin
          if (shadow_depth != 1) begin
            flag_error(ST_UNBALANCED, 1'b1);
          end else begin
            push_instr(OP_LD, lhs, ST_OK, 1'b0);
            push_instr(op, rhs, ST_OK, 1'b1);
            clear_expr();
          end
        end else begin
          push_instr(OP_LD, lhs, ST_OK, 1'b0);
          push_instr(op, rhs, ST_OK, 1'b0);
          push_instr(OP_ST, tmp, ST_OK, 1'b1);
        end
      end
    end else begin
      flag_error(ST_BADCHAR, lst);
    end
  endtask

  // input driver, fed from the pending queue
  always @(posedge clk) begin
    bit fire;
    bit send;
    fire = in_chan.valid && in_chan.ready;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || fire) begin
      if (fire) void'(pending_q.pop_front());
      send = pending_q.size() != 0 && (hold_left > 0 || !take_break());
      in_chan.valid <= send;
      if (send) begin
        in_chan.ch   <= pending_q[0].ch;
        in_chan.last <= pending_q[0].last;
      end
    end
  end

  // long receiver hold-off, once, while the sender keeps offering
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // monitor: predict on accepted input words, check accepted result words
  always @(posedge clk) begin
    instr_word_t want;
    if (!rst_n) begin
      clear_expr();
      out_chan.ready <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        predict_instrs(in_chan.ch, in_chan.last);
        n_taken <= n_taken + 1;
      end
      if (out_chan.valid && out_chan.ready) begin
        if (instr_q.size() == 0) begin
          report("result word with nothing expected");
        end else begin
          want = instr_q.pop_front();
          check_field("opcode", out_chan.opcode, want.op);
          check_field("operand_is_temp", out_chan.operand_is_temp, want.is_temp);
          check_field("operand_value", out_chan.operand_value, want.value);
          check_field("status", out_chan.status, want.st);
          check_field("last_of_run", out_chan.last_of_run, want.run_end);
        end
      end
      out_chan.ready <= hold_left == 0 && !take_break();
    end
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return CH_UP_A + 8'($urandom_range(0, 25));
    return CH_LO_A + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  task automatic add_char(input logic [7:0] c, input logic lst);
    char_word_t w;
    w.ch   = c;
    w.last = lst;
    pending_q = {pending_q, w};
  endtask

  // whole expression, last flag on its final character
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
  endtask

  // random expressions, mostly well formed, some broken, some noise
  task automatic add_random(input int n_items);
    char_word_t seq[$];
    char_word_t w;
    int         goal;
    int         kind;
    int         n_let;
    int         depth;
    int         k;
    goal = pending_q.size() + n_items;
    while (pending_q.size() < goal) begin
      kind = $urandom_range(0, 99);
      if (kind >= 85) begin
        add_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        seq.delete();
        n_let = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(1, 4);
        depth = 0;
        while (n_let > 0 || depth > 1) begin
          if (n_let > 0 && (depth < 2 || $urandom_range(0, 1))) begin
            w = '{ch: rand_letter(), last: 1'b0};
            seq = {seq, w};
            n_let--;
            depth++;
          end else begin
            w = '{ch: rand_op(), last: 1'b0};
            seq = {seq, w};
            depth--;
          end
        end
        seq[seq.size() - 1].last = 1'b1;
        // broken variants: a stray byte, an early end, an extra operator
        if (kind >= 65) begin
          k = $urandom_range(0, seq.size() - 1);
          case ($urandom_range(0, 2))
            0:       seq[k].ch = 8'($urandom_range(0, 255));
            1:       seq[k].last = 1'b1;
            default: seq.insert(k, '{ch: rand_op(), last: 1'b0});
          endcase
        end
        pending_q = {pending_q, seq};
      end
    end
  endtask

  // stimulus, reset and end of run
  initial begin
    int total;

    // directed: all operators, letter extremes, underflow, bad character and unbalanced errors
    add_text("ab+");
    add_text("ab-c*");
    add_text("Zz/");
    add_text("A");
    add_text("+");
    add_char("a", 1'b0);
    add_char(CH_PLUS, 1'b0);
    add_char("b", 1'b0);
    add_char("c", 1'b1);
    add_char(8'h00, 1'b1);
    add_char(8'hFF, 1'b0);
    add_char("x", 1'b1);
    add_text("ab");
    add_text("abc+");

    add_random(15);

    // end any open expression, then one letter past full depth overflows the stack
    add_char("q", 1'b1);
    for (int i = 0; i <= STACK_DEPTH; i++) add_char(rand_letter(), 1'b0);
    add_char(rand_letter(), 1'b1);

    add_random(15);

    total = pending_q.size();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (n_taken < total || instr_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
